FILE: design/rsbf_pkg.sv
// Shared types and constants of the RGB565 rectangle scaler with box filter.
// Field widths, register indexes, word codes and default parameter values.
// No dependencies; used by rgb565_rect_scaler_box_filter.
package rsbf_pkg;

   // Widths of the word fields.
   localparam int XW   = 10;   // canvas or panel column
   localparam int YW   = 9;    // canvas or panel row
   localparam int PIXW = 16;   // RGB565 pixel

   // Stream word layout.
   localparam int REQ_TDATA_W = 40;   // pos_x, pos_y, pixel_in, padded to 5 bytes
   localparam int RSP_TDATA_W = 24;   // pixel_out, rect_empty, padded to 3 bytes

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CANVAS_WIDTH  = 3'd0,
      REG_CANVAS_HEIGHT = 3'd1,
      REG_RECT_LEFT     = 3'd2,
      REG_RECT_TOP      = 3'd3,
      REG_RECT_WIDTH    = 3'd4,
      REG_RECT_HEIGHT   = 3'd5,
      REG_SMOOTHING     = 3'd6,
      REG_BYTE_SWAP     = 3'd7
   } csr_index_type;

   // Word kind carried in req_tuser.
   localparam logic MODE_WRITE   = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   // Register reset values.
   localparam logic [XW-1:0] RST_CANVAS_WIDTH  = 10'd640;
   localparam logic [YW-1:0] RST_CANVAS_HEIGHT = 9'd480;

   // Default geometry.
   localparam int DEF_PANEL_WIDTH       = 320;
   localparam int DEF_PANEL_HEIGHT      = 240;
   localparam int DEF_MAX_CANVAS_WIDTH  = 640;
   localparam int DEF_MAX_CANVAS_HEIGHT = 480;

endpackage

FILE: design/rgb565_rect_scaler_box_filter.sv
// Top level of the RGB565 rectangle scaler with 2x2 box filter: a seven-register
// pipeline around a frame store split into four parity banks.
// Depends on rsbf_pkg for widths, register indexes and word codes.

// The block keeps an RGB565 canvas in a frame store and answers panel pixel
// requests. A write word (req_tuser low) stores one canvas pixel and gives no
// response; a request word (req_tuser high) names one panel pixel and gives one
// response word with the scaled, box-filtered and optionally byte-swapped pixel.
// The block takes one word per clock cycle and delivers one response per cycle
// while rsp_tready does not hold it back. Each pipeline stage holds its own
// valid bit, so bubbles close up and req_tready stays high while the response
// register waits on rsp_tready, as long as an earlier stage is empty. The rate
// is set by the frame store: it is split into four banks by column and row
// parity, so all four taps of the 2x2 filter are read together from one port
// per bank, and a write word uses the same port in the same stage, which keeps
// every write ahead of any later read. The store has no reset and no clearing
// pass; a canvas entry must be written before it is read. The user must write
// configuration through the csr_ port while no word is in flight; not enforced.
module rgb565_rect_scaler_box_filter #(
   parameter int PANEL_WIDTH       = rsbf_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT      = rsbf_pkg::DEF_PANEL_HEIGHT,
   parameter int MAX_CANVAS_WIDTH  = rsbf_pkg::DEF_MAX_CANVAS_WIDTH,
   parameter int MAX_CANVAS_HEIGHT = rsbf_pkg::DEF_MAX_CANVAS_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request side.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: pos_x[9:0], pos_y[18:10], pixel_in[34:19], zero pad.
   input  logic [rsbf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Fields: mode (0 write canvas pixel, 1 request panel pixel).
   input  logic                                req_tuser,
   // Response side.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: pixel_out[15:0], rect_empty[16], zero pad.
   output logic [rsbf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [rsbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsbf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int XW   = rsbf_pkg::XW;
   localparam int YW   = rsbf_pkg::YW;
   localparam int PIXW = rsbf_pkg::PIXW;

   // Products of panel position and rectangle size, and the exact reciprocal
   // used to divide them by the panel size: with K = N + clog2(d), the value
   // ceil(2^K / d) gives floor(n / d) for every n below 2^N.
   localparam int PX_W  = 2 * XW;
   localparam int PY_W  = 2 * YW;
   localparam int QX_K  = PX_W + $clog2(PANEL_WIDTH);
   localparam int QY_K  = PY_W + $clog2(PANEL_HEIGHT);
   localparam int QX_MW = PX_W + 2;
   localparam int QY_MW = PY_W + 2;
   localparam longint QX_M = ((64'd1 << QX_K) + PANEL_WIDTH - 1) / PANEL_WIDTH;
   localparam longint QY_M = ((64'd1 << QY_K) + PANEL_HEIGHT - 1) / PANEL_HEIGHT;

   // Parity banks of the frame store.
   localparam int BANK_W     = (MAX_CANVAS_WIDTH + 1) / 2;
   localparam int BANK_H     = (MAX_CANVAS_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = BANK_W * BANK_H;
   localparam int BCW        = $clog2(BANK_W);
   localparam int BRW        = $clog2(BANK_H);
   localparam int BAW        = $clog2(BANK_DEPTH);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [XW-1:0] canvas_w_ff;
   logic [YW-1:0] canvas_h_ff;
   logic [XW-1:0] rect_left_ff;
   logic [YW-1:0] rect_top_ff;
   logic [XW-1:0] rect_w_ff;
   logic [YW-1:0] rect_h_ff;
   logic          smoothing_ff;
   logic          byte_swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_w_ff  <= rsbf_pkg::RST_CANVAS_WIDTH;
         canvas_h_ff  <= rsbf_pkg::RST_CANVAS_HEIGHT;
         rect_left_ff <= '0;
         rect_top_ff  <= '0;
         rect_w_ff    <= '0;
         rect_h_ff    <= '0;
         smoothing_ff <= 1'b1;
         byte_swap_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (rsbf_pkg::csr_index_type'(csr_index))
            rsbf_pkg::REG_CANVAS_WIDTH:  canvas_w_ff  <= csr_wdata[XW-1:0];
            rsbf_pkg::REG_CANVAS_HEIGHT: canvas_h_ff  <= csr_wdata[YW-1:0];
            rsbf_pkg::REG_RECT_LEFT:     rect_left_ff <= csr_wdata[XW-1:0];
            rsbf_pkg::REG_RECT_TOP:      rect_top_ff  <= csr_wdata[YW-1:0];
            rsbf_pkg::REG_RECT_WIDTH:    rect_w_ff    <= csr_wdata[XW-1:0];
            rsbf_pkg::REG_RECT_HEIGHT:   rect_h_ff    <= csr_wdata[YW-1:0];
            rsbf_pkg::REG_SMOOTHING:     smoothing_ff <= csr_wdata[0];
            rsbf_pkg::REG_BYTE_SWAP:     byte_swap_ff <= csr_wdata[0];
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when the
   // stage after it moves on, so a stall never drops or repeats a word.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en6, en7;

   assign en7 = !rsp_valid_ff || rsp_tready;
   assign en6 = !s6_valid_ff || en7;
   assign en5 = !s5_valid_ff || en6;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_tready = en1;

   // ------------------------------------------------------------------
   // Stage 1: capture the incoming word.
   // ------------------------------------------------------------------
   logic            s1_mode_ff;
   logic [XW-1:0]   s1_x_ff;
   logic [YW-1:0]   s1_y_ff;
   logic [PIXW-1:0] s1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_mode_ff <= req_tuser;
         s1_x_ff    <= req_tdata[XW-1:0];
         s1_y_ff    <= req_tdata[XW +: YW];
         s1_pix_ff  <= req_tdata[XW + YW +: PIXW];
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: active rectangle, clipping, empty test and panel clamping.
   // The rectangle falls back to the whole canvas when either size is
   // zero, and is cut at the right and bottom canvas edges.
   // ------------------------------------------------------------------
   logic [XW-1:0] cw, fx, fw, sw_eff, x_sel;
   logic [YW-1:0] ch, fy, fh, sh_eff, y_sel;
   logic          fallback, empty_x, empty_y, write_ok, is_req;

   always_comb begin
      cw = (int'(canvas_w_ff) > MAX_CANVAS_WIDTH) ? XW'(MAX_CANVAS_WIDTH) : canvas_w_ff;
      ch = (int'(canvas_h_ff) > MAX_CANVAS_HEIGHT) ? YW'(MAX_CANVAS_HEIGHT) : canvas_h_ff;
      fallback = (rect_w_ff == '0) || (rect_h_ff == '0);
      fx = fallback ? '0 : rect_left_ff;
      fy = fallback ? '0 : rect_top_ff;
      fw = fallback ? cw : rect_w_ff;
      fh = fallback ? ch : rect_h_ff;
      // The clipped size is positive only when the rectangle starts inside.
      empty_x = (fw == '0) || (fx >= cw);
      empty_y = (fh == '0) || (fy >= ch);
      sw_eff = (({1'b0, fx} + {1'b0, fw}) > {1'b0, cw}) ? XW'(cw - fx) : fw;
      sh_eff = (({1'b0, fy} + {1'b0, fh}) > {1'b0, ch}) ? YW'(ch - fy) : fh;
      is_req = (s1_mode_ff == rsbf_pkg::MODE_REQUEST);
      write_ok = !is_req && (s1_x_ff < cw) && (s1_y_ff < ch);
      // Requests beyond the panel stick to its last column or row; writes
      // keep their canvas position.
      x_sel = s1_x_ff;
      y_sel = s1_y_ff;
      if (is_req && int'(s1_x_ff) > PANEL_WIDTH - 1) begin
         x_sel = XW'(PANEL_WIDTH - 1);
      end
      if (is_req && int'(s1_y_ff) > PANEL_HEIGHT - 1) begin
         y_sel = YW'(PANEL_HEIGHT - 1);
      end
   end

   logic            s2_req_ff, s2_wr_ff, s2_empty_ff;
   logic [XW-1:0]   s2_sx_ff, s2_sw_ff, s2_x_ff;
   logic [YW-1:0]   s2_sy_ff, s2_sh_ff, s2_y_ff;
   logic [PIXW-1:0] s2_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_req_ff   <= is_req;
         s2_wr_ff    <= write_ok;
         s2_empty_ff <= empty_x || empty_y;
         s2_sx_ff    <= fx;
         s2_sy_ff    <= fy;
         s2_sw_ff    <= sw_eff;
         s2_sh_ff    <= sh_eff;
         s2_x_ff     <= x_sel;
         s2_y_ff     <= y_sel;
         s2_pix_ff   <= s1_pix_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: scale products, panel position times rectangle size.
   // ------------------------------------------------------------------
   logic            s3_req_ff, s3_wr_ff, s3_empty_ff;
   logic [XW-1:0]   s3_sx_ff, s3_sw_ff, s3_x_ff;
   logic [YW-1:0]   s3_sy_ff, s3_sh_ff, s3_y_ff;
   logic [PIXW-1:0] s3_pix_ff;
   logic [PX_W-1:0] s3_prod_x_ff;
   logic [PY_W-1:0] s3_prod_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_req_ff    <= s2_req_ff;
         s3_wr_ff     <= s2_wr_ff;
         s3_empty_ff  <= s2_empty_ff;
         s3_sx_ff     <= s2_sx_ff;
         s3_sy_ff     <= s2_sy_ff;
         s3_sw_ff     <= s2_sw_ff;
         s3_sh_ff     <= s2_sh_ff;
         s3_x_ff      <= s2_x_ff;
         s3_y_ff      <= s2_y_ff;
         s3_pix_ff    <= s2_pix_ff;
         s3_prod_x_ff <= PX_W'(s2_x_ff * s2_sw_ff);
         s3_prod_y_ff <= PY_W'(s2_y_ff * s2_sh_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: divide by the panel size through the exact reciprocal.
   // ------------------------------------------------------------------
   logic [QX_MW-1:0]      qx_m;
   logic [QY_MW-1:0]      qy_m;
   logic [PX_W+QX_MW-1:0] qx_prod;
   logic [PY_W+QY_MW-1:0] qy_prod;

   assign qx_m    = QX_MW'(QX_M);
   assign qy_m    = QY_MW'(QY_M);
   assign qx_prod = (PX_W + QX_MW)'(s3_prod_x_ff * qx_m);
   assign qy_prod = (PY_W + QY_MW)'(s3_prod_y_ff * qy_m);

   logic            s4_req_ff, s4_wr_ff, s4_empty_ff;
   logic [XW-1:0]   s4_sx_ff, s4_sw_ff, s4_x_ff, s4_col_ff;
   logic [YW-1:0]   s4_sy_ff, s4_sh_ff, s4_y_ff, s4_row_ff;
   logic [PIXW-1:0] s4_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_req_ff   <= s3_req_ff;
         s4_wr_ff    <= s3_wr_ff;
         s4_empty_ff <= s3_empty_ff;
         s4_sx_ff    <= s3_sx_ff;
         s4_sy_ff    <= s3_sy_ff;
         s4_sw_ff    <= s3_sw_ff;
         s4_sh_ff    <= s3_sh_ff;
         s4_x_ff     <= s3_x_ff;
         s4_y_ff     <= s3_y_ff;
         s4_pix_ff   <= s3_pix_ff;
         s4_col_ff   <= qx_prod[QX_K +: XW];
         s4_row_ff   <= qy_prod[QY_K +: YW];
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: canvas position of the top-left tap and the second-tap
   // decision. A shrinking axis with smoothing on takes the next pixel,
   // except at the last column or row of the rectangle.
   // ------------------------------------------------------------------
   logic          step_x, step_y;
   logic [XW-1:0] acol;
   logic [YW-1:0] arow;

   always_comb begin
      step_x = smoothing_ff && (int'(s4_sw_ff) > PANEL_WIDTH)
               && (({1'b0, s4_col_ff} + (XW+1)'(1)) < {1'b0, s4_sw_ff});
      step_y = smoothing_ff && (int'(s4_sh_ff) > PANEL_HEIGHT)
               && (({1'b0, s4_row_ff} + (YW+1)'(1)) < {1'b0, s4_sh_ff});
      acol = s4_req_ff ? XW'(s4_sx_ff + s4_col_ff) : s4_x_ff;
      arow = s4_req_ff ? YW'(s4_sy_ff + s4_row_ff) : s4_y_ff;
   end

   logic            s5_req_ff, s5_wr_ff, s5_empty_ff, s5_step_x_ff, s5_step_y_ff;
   logic [XW-1:0]   s5_acol_ff;
   logic [YW-1:0]   s5_arow_ff;
   logic [PIXW-1:0] s5_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en5) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_req_ff    <= s4_req_ff;
         s5_wr_ff     <= s4_wr_ff;
         s5_empty_ff  <= s4_empty_ff;
         s5_step_x_ff <= step_x;
         s5_step_y_ff <= step_y;
         s5_acol_ff   <= acol;
         s5_arow_ff   <= arow;
         s5_pix_ff    <= s4_pix_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: frame store access. Bank {row parity, column parity} holds
   // every second pixel in both directions. The 2x2 block at (acol, arow)
   // touches each bank once, so all four taps come out together. A write
   // word uses the same address in the bank that matches its parity.
   // ------------------------------------------------------------------
   logic [BAW-1:0]  bank_addr [4];
   logic            bank_we   [4];
   logic [PIXW-1:0] s6_rd_ff  [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic BPC = 1'(b % 2);
      localparam logic BPR = 1'(b / 2);

      logic [XW-1:0]   col_half;
      logic [YW-1:0]   row_half;
      logic [BCW-1:0]  col_idx;
      logic [BRW-1:0]  row_idx;
      logic [PIXW-1:0] store_ff [BANK_DEPTH];

      // The odd bank takes acol or acol+1, whichever is odd: both halve to
      // acol >> 1. The even bank needs (acol + 1) >> 1.
      assign col_half = BPC ? (s5_acol_ff >> 1)
                            : XW'(({1'b0, s5_acol_ff} + (XW+1)'(1)) >> 1);
      assign row_half = BPR ? (s5_arow_ff >> 1)
                            : YW'(({1'b0, s5_arow_ff} + (YW+1)'(1)) >> 1);
      // Past the last stored column or row only an unused tap is read.
      assign col_idx = (int'(col_half) > BANK_W - 1) ? BCW'(BANK_W - 1) : BCW'(col_half);
      assign row_idx = (int'(row_half) > BANK_H - 1) ? BRW'(BANK_H - 1) : BRW'(row_half);
      assign bank_addr[b] = BAW'(int'(row_idx) * BANK_W + int'(col_idx));
      assign bank_we[b] = en6 && s5_valid_ff && s5_wr_ff
                          && (s5_acol_ff[0] == BPC) && (s5_arow_ff[0] == BPR);

      always_ff @(posedge clock) begin
         if (bank_we[b]) begin
            store_ff[bank_addr[b]] <= s5_pix_ff;
         end
         if (en6) begin
            s6_rd_ff[b] <= store_ff[bank_addr[b]];
         end
      end
   end

   logic s6_empty_ff, s6_c0_ff, s6_r0_ff, s6_step_x_ff, s6_step_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en6) begin
         // Write words end here.
         s6_valid_ff <= s5_valid_ff && s5_req_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_empty_ff  <= s5_empty_ff;
         s6_c0_ff     <= s5_acol_ff[0];
         s6_r0_ff     <= s5_arow_ff[0];
         s6_step_x_ff <= s5_step_x_ff;
         s6_step_y_ff <= s5_step_y_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: tap selection, per-channel average of four taps, a black pixel for
   // an empty rectangle and the optional byte swap. An axis with one tap uses that tap twice.
   // ------------------------------------------------------------------
   logic [PIXW-1:0] tap [4];
   logic [6:0]      sum_r, sum_b;
   logic [7:0]      sum_g;
   logic [PIXW-1:0] avg_pix, out_pix;
   logic            c1, r1;

   always_comb begin
      c1 = s6_c0_ff ^ s6_step_x_ff;
      r1 = s6_r0_ff ^ s6_step_y_ff;
      tap[0] = s6_rd_ff[{s6_r0_ff, s6_c0_ff}];
      tap[1] = s6_rd_ff[{s6_r0_ff, c1}];
      tap[2] = s6_rd_ff[{r1, s6_c0_ff}];
      tap[3] = s6_rd_ff[{r1, c1}];
      sum_r = 7'(tap[0][15:11]) + 7'(tap[1][15:11]) + 7'(tap[2][15:11]) + 7'(tap[3][15:11]);
      sum_g = 8'(tap[0][10:5]) + 8'(tap[1][10:5]) + 8'(tap[2][10:5]) + 8'(tap[3][10:5]);
      sum_b = 7'(tap[0][4:0]) + 7'(tap[1][4:0]) + 7'(tap[2][4:0]) + 7'(tap[3][4:0]);
      avg_pix = {sum_r[6:2], sum_g[7:2], sum_b[6:2]};
      if (s6_empty_ff) begin
         out_pix = '0;
      end else if (byte_swap_ff) begin
         out_pix = {avg_pix[7:0], avg_pix[15:8]};
      end else begin
         out_pix = avg_pix;
      end
   end

   logic [PIXW-1:0] rsp_pixel_ff;
   logic            rsp_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en7) begin
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         rsp_pixel_ff <= out_pix;
         rsp_empty_ff <= s6_empty_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(rsbf_pkg::RSP_TDATA_W - PIXW - 1)'(0), rsp_empty_ff, rsp_pixel_ff};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // An empty rectangle always answers with a black pixel.
   a_empty_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_pixel_ff == '0)
      else $error("empty rectangle response carries a nonzero pixel");

   // A write word lands in at most one bank.
   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({bank_we[3], bank_we[2], bank_we[1], bank_we[0]}))
      else $error("write word enabled more than one bank");

   // Clamped bank addresses stay inside the banks.
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (int'(bank_addr[0]) < BANK_DEPTH) && (int'(bank_addr[1]) < BANK_DEPTH)
                      && (int'(bank_addr[2]) < BANK_DEPTH) && (int'(bank_addr[3]) < BANK_DEPTH))
      else $error("frame store bank address out of range");

   // A request leaving the store stage reaches the filter stage.
   a_request_kept: assert property (@(posedge clock) disable iff (reset)
      en6 && s5_valid_ff && s5_req_ff |=> s6_valid_ff)
      else $error("request word lost at the frame store stage");

   // A write word never produces a response.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      en6 && s5_valid_ff && !s5_req_ff |=> !s6_valid_ff)
      else $error("write word produced a response");

endmodule
